// ===== src/hel_pkg.sv =====
package hel_pkg;

  // Field widths of the sample and result transactions.
  localparam int ADC_W  = 10;
  localparam int BAND_W = 8;
  localparam int LAP_W  = 24;
  localparam int FRAC_W = 16;
  localparam int Q_W    = ADC_W + FRAC_W;

  // The group counters hold at most sixteen samples or measurements.
  localparam int CNT_W = 4;

  localparam logic [BAND_W-1:0] BAND_RESET = 8'd5;
  localparam logic [LAP_W-1:0]  LAP_MAX    = {LAP_W{1'b1}};

  // Exponential average: new = floor((99 * old + m) / 100), computed as
  // old + floor((m - old) / 100). The difference is below 2^24 whenever the
  // average runs, so the divide is a multiply by ceil(2^32 / 100).
  localparam int EMA_DIV     = 100;
  localparam int EMA_SHIFT   = 32;
  localparam int EMA_ARG_W   = 25;
  localparam int EMA_RECIP_W = 26;
  localparam int EMA_QUO_W   = 19;
  localparam longint unsigned EMA_RECIP =
      ((64'd1 << EMA_SHIFT) + EMA_DIV - 1) / EMA_DIV;
  localparam logic [EMA_ARG_W-1:0] EMA_ROUND = EMA_ARG_W'(EMA_DIV - 1);

  typedef enum logic [1:0] {
    EXC_INSIDE = 2'd0,
    EXC_LOW    = 2'd1,
    EXC_HIGH   = 2'd2
  } exc_state_t;

  typedef struct packed {
    logic [LAP_W-1:0] lap_count;
    logic             lap_event;
    logic [ADC_W-1:0] baseline_level;
    logic [ADC_W-1:0] measurement;
    logic             calibrated;
  } result_t;

endpackage

// ===== src/hel_if.sv =====
interface sample_if;
  logic                        valid;
  logic                        ready;
  logic [hel_pkg::ADC_W-1:0]   adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface result_if;
  logic                        valid;
  logic                        ready;
  logic [hel_pkg::LAP_W-1:0]   lap_count;
  logic                        lap_event;
  logic [hel_pkg::ADC_W-1:0]   baseline_level;
  logic [hel_pkg::ADC_W-1:0]   measurement;
  logic                        calibrated;

  modport source (output valid, output lap_count, output lap_event,
                  output baseline_level, output measurement, output calibrated,
                  input ready);
  modport sink   (input valid, input lap_count, input lap_event,
                  input baseline_level, input measurement, input calibrated,
                  output ready);
endinterface

// ===== src/hel_accum.sv =====
module hel_accum #(
  parameter int SAMPLES_PER_MEASURE = 10,
  localparam int SUM_W = $clog2(SAMPLES_PER_MEASURE * 1023 + 1)
) (
  input  logic             clk,
  input  logic             rst,
  sample_if.sink           samples,
  input  logic             busy,
  output logic             start,
  output logic [SUM_W-1:0] start_sum
);

  logic [SUM_W-1:0]          group_sum;
  logic [hel_pkg::CNT_W-1:0] group_index;
  logic                      last;
  logic                      accept;
  logic [SUM_W-1:0]          sum_next;

  // The closing sample of a group waits while the measurement unit is busy.
  assign last          = (group_index == hel_pkg::CNT_W'(SAMPLES_PER_MEASURE - 1));
  assign samples.ready = !(last && busy);
  assign accept        = samples.valid && samples.ready;
  assign sum_next      = group_sum + SUM_W'(samples.adc_sample);
  assign start         = accept && last;
  assign start_sum     = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum   <= '0;
      group_index <= '0;
    end else if (accept) begin
      if (last) begin
        group_sum   <= '0;
        group_index <= '0;
      end else begin
        group_sum   <= sum_next;
        group_index <= group_index + 1'b1;
      end
    end
  end

endmodule

// ===== src/hel_measure.sv =====
module hel_measure #(
  parameter int SAMPLES_PER_MEASURE  = 10,
  parameter int CALIBRATION_MEASURES = 10,
  localparam int SUM_W = $clog2(SAMPLES_PER_MEASURE * 1023 + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             start_sum,
  input  logic [hel_pkg::BAND_W-1:0]   band,
  input  logic                         out_free,
  output logic                         busy,
  output logic                         res_valid,
  output hel_pkg::result_t             res
);

  localparam int DIV_C = SAMPLES_PER_MEASURE * CALIBRATION_MEASURES;
  localparam int CAL_W = $clog2(DIV_C * 1023 + 1);
  // Reciprocals exact over the full range of each dividend.
  localparam int S1   = SUM_W + 4;
  localparam int M1_W = S1 + 1;
  localparam longint unsigned M1 =
      ((64'd1 << S1) + SAMPLES_PER_MEASURE - 1) / SAMPLES_PER_MEASURE;
  localparam int SC   = CAL_W + 8;
  localparam int MC_W = SC + 1;
  localparam longint unsigned MC = ((64'd1 << SC) + DIV_C - 1) / DIV_C;
  localparam int Q_W  = hel_pkg::Q_W;
  localparam int A_W  = hel_pkg::ADC_W;
  localparam int F_W  = hel_pkg::FRAC_W;

  // Fraction tables: floor(r * 2^16 / divisor) for each remainder r.
  logic [F_W-1:0] frac_s [16];
  logic [F_W-1:0] frac_c [256];

  for (genvar g = 0; g < 16; g++) begin : g_frac_s
    if (g < SAMPLES_PER_MEASURE) begin : g_used
      assign frac_s[g] = F_W'((g * 65536) / SAMPLES_PER_MEASURE);
    end else begin : g_unused
      assign frac_s[g] = '0;
    end
  end

  for (genvar g = 0; g < 256; g++) begin : g_frac_c
    if (g < DIV_C) begin : g_used
      assign frac_c[g] = F_W'((g * 65536) / DIV_C);
    end else begin : g_unused
      assign frac_c[g] = '0;
    end
  end

  logic [M1_W-1:0]                m1_c;
  logic [MC_W-1:0]                mc_c;
  logic [hel_pkg::EMA_RECIP_W-1:0] ema_c;
  assign m1_c  = M1_W'(M1);
  assign mc_c  = MC_W'(MC);
  assign ema_c = hel_pkg::EMA_RECIP_W'(hel_pkg::EMA_RECIP);

  // Persistent state.
  logic [Q_W-1:0]            baseline;
  hel_pkg::exc_state_t       exc_state, exc_next;
  logic [hel_pkg::LAP_W-1:0] lap_total;
  logic                      is_calibrated;
  logic [CAL_W-1:0]          cal_sum;
  logic [hel_pkg::CNT_W-1:0] cal_index;

  logic v1, v2, v3, adv;

  // Stage 1: exact measurement, band gate, calibration sum.
  logic [SUM_W-1:0]           s1_sum;
  logic [SUM_W+M1_W-1:0]      prod1;
  logic [A_W-1:0]             q1;
  logic [SUM_W-1:0]           rem1;
  logic [Q_W-1:0]             mq1;
  logic [Q_W:0]               d1, dabs1;
  logic [hel_pkg::EMA_ARG_W-1:0] u1;
  logic [Q_W:0]               band_q;
  logic                       inband1;
  logic [CAL_W-1:0]           cal_total1;
  logic                       cal_last1;

  assign band_q = {3'b000, band, {F_W{1'b0}}};

  always_comb begin
    prod1      = (SUM_W + M1_W)'(s1_sum) * (SUM_W + M1_W)'(m1_c);
    q1         = A_W'(prod1 >> S1);
    rem1       = s1_sum - SUM_W'(int'(q1) * SAMPLES_PER_MEASURE);
    mq1        = {q1, frac_s[rem1[3:0]]};
    d1         = {1'b0, mq1} - {1'b0, baseline};
    dabs1      = d1[Q_W] ? ((Q_W + 1)'(0) - d1) : d1;
    inband1    = dabs1 < band_q;
    u1         = d1[Q_W] ? (hel_pkg::EMA_ARG_W'(dabs1) + hel_pkg::EMA_ROUND)
                         : hel_pkg::EMA_ARG_W'(dabs1);
    cal_total1 = cal_sum + CAL_W'(s1_sum);
    cal_last1  = (cal_index == hel_pkg::CNT_W'(CALIBRATION_MEASURES - 1));
  end

  // Stage 2: the two constant divides.
  logic [Q_W-1:0]                 s2_mq;
  logic [hel_pkg::EMA_ARG_W-1:0]  s2_u;
  logic                           s2_neg, s2_inband, s2_cal, s2_cal_last;
  logic [CAL_W-1:0]               s2_cal_total;
  logic [hel_pkg::EMA_ARG_W+hel_pkg::EMA_RECIP_W-1:0] prod_ema;
  logic [CAL_W+MC_W-1:0]          prod_cal;

  assign prod_ema = (hel_pkg::EMA_ARG_W + hel_pkg::EMA_RECIP_W)'(s2_u)
                  * (hel_pkg::EMA_ARG_W + hel_pkg::EMA_RECIP_W)'(ema_c);
  assign prod_cal = (CAL_W + MC_W)'(s2_cal_total) * (CAL_W + MC_W)'(mc_c);

  // Stage 3: new baseline, window compare, lap count.
  logic [Q_W-1:0]                 s3_mq;
  logic                           s3_neg, s3_inband, s3_cal, s3_cal_last;
  logic [CAL_W-1:0]               s3_cal_total;
  logic [hel_pkg::EMA_QUO_W-1:0]  s3_qd;
  logic [A_W-1:0]                 s3_qc;

  logic [CAL_W-1:0]          remc;
  logic [Q_W-1:0]            cal_base, b_ema, b_new;
  logic [A_W-1:0]            fm;
  logic [Q_W:0]              f_q;
  logic                      below, above, lap_hit, cal_next;
  logic [hel_pkg::LAP_W-1:0] lap_next;

  always_comb begin
    remc     = s3_cal_total - CAL_W'(int'(s3_qc) * DIV_C);
    cal_base = {s3_qc, frac_c[remc[7:0]]};
    b_ema    = s3_neg ? (baseline - Q_W'(s3_qd)) : (baseline + Q_W'(s3_qd));
    if (s3_cal) begin
      b_new = s3_cal_last ? cal_base : baseline;
    end else begin
      b_new = s3_inband ? b_ema : baseline;
    end
    fm    = s3_mq[Q_W-1:F_W];
    f_q   = {1'b0, fm, {F_W{1'b0}}};
    below = (f_q + band_q) < {1'b0, b_new};
    above = f_q > ({1'b0, b_new} + band_q);
  end

  // Excursion tracker; it only runs once the baseline is set.
  always_comb begin
    exc_next = exc_state;
    lap_hit  = 1'b0;
    if (!s3_cal) begin
      case (exc_state)
        hel_pkg::EXC_LOW: begin
          if (!below) begin
            lap_hit  = 1'b1;
            exc_next = above ? hel_pkg::EXC_HIGH : hel_pkg::EXC_INSIDE;
          end
        end
        hel_pkg::EXC_HIGH: begin
          if (!above) begin
            lap_hit  = 1'b1;
            exc_next = hel_pkg::EXC_INSIDE;
          end
        end
        default: begin
          if (below) begin
            exc_next = hel_pkg::EXC_LOW;
          end else if (above) begin
            exc_next = hel_pkg::EXC_HIGH;
          end else begin
            exc_next = hel_pkg::EXC_INSIDE;
          end
        end
      endcase
    end
  end

  always_comb begin
    lap_next = lap_total;
    if (lap_hit && (lap_total != hel_pkg::LAP_MAX)) begin
      lap_next = lap_total + 1'b1;
    end
    cal_next = is_calibrated || (s3_cal && s3_cal_last);
    res.lap_count      = lap_next;
    res.lap_event      = lap_hit;
    res.baseline_level = b_new[Q_W-1:F_W];
    res.measurement    = fm;
    res.calibrated     = cal_next;
  end

  assign adv       = v3 && out_free;
  assign res_valid = adv;
  // A new group may enter in the same cycle the last one retires.
  assign busy      = v1 || v2 || (v3 && !out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2 || (v3 && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_sum <= start_sum;
    end
    if (v1) begin
      s2_mq        <= mq1;
      s2_u         <= u1;
      s2_neg       <= d1[Q_W];
      s2_inband    <= inband1;
      s2_cal       <= !is_calibrated;
      s2_cal_last  <= cal_last1;
      s2_cal_total <= cal_total1;
    end
    if (v2) begin
      s3_mq        <= s2_mq;
      s3_neg       <= s2_neg;
      s3_inband    <= s2_inband;
      s3_cal       <= s2_cal;
      s3_cal_last  <= s2_cal_last;
      s3_cal_total <= s2_cal_total;
      s3_qd        <= hel_pkg::EMA_QUO_W'(prod_ema >> hel_pkg::EMA_SHIFT);
      s3_qc        <= A_W'(prod_cal >> SC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_sum   <= '0;
      cal_index <= '0;
    end else if (v1 && !is_calibrated) begin
      if (cal_last1) begin
        cal_sum   <= '0;
        cal_index <= '0;
      end else begin
        cal_sum   <= cal_total1;
        cal_index <= cal_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline      <= '0;
      exc_state     <= hel_pkg::EXC_INSIDE;
      lap_total     <= '0;
      is_calibrated <= 1'b0;
    end else if (adv) begin
      baseline      <= b_new;
      exc_state     <= exc_next;
      lap_total     <= lap_next;
      is_calibrated <= cal_next;
    end
  end

endmodule

// ===== src/hall_excursion_lap_counter.sv =====
// A result goes from the sample that closes its group through the stage 1, 2
// and 3 registers and the result register. Throughput: one sample per cycle
// while SAMPLES_PER_MEASURE >= 3 and results are taken; the three-stage
// measurement unit holds one group at a time. One result per group of samples.
// Reset (rst, synchronous, active high) clears the group and calibration sums,
// counters, baseline, excursion state and lap count, and sets the band half width to 5.
module hall_excursion_lap_counter #(
  parameter int SAMPLES_PER_MEASURE  = 10,
  parameter int CALIBRATION_MEASURES = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [hel_pkg::BAND_W-1:0] cfg_wr_data,
  sample_if.sink                     samples,
  result_if.source                   results
);

  localparam int SUM_W = $clog2(SAMPLES_PER_MEASURE * 1023 + 1);

  // Band half width register. Writes are to arrive only while the block is idle; the block does not enforce this.
  logic [hel_pkg::BAND_W-1:0] band;

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= hel_pkg::BAND_RESET;
    end else if (cfg_wr_en) begin
      band <= cfg_wr_data;
    end
  end

  // The accumulator sums each group of samples. When the last sample of a
  // group is accepted it hands the group sum to the measurement unit.
  logic             start;
  logic [SUM_W-1:0] start_sum;
  logic             busy;

  hel_accum #(
    .SAMPLES_PER_MEASURE (SAMPLES_PER_MEASURE)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .busy      (busy),
    .start     (start),
    .start_sum (start_sum)
  );

  // The measurement unit forms the Q10.16 measurement, runs calibration or
  // the gated exponential average, and then the window comparator that
  // tracks excursions and counts laps.
  logic             out_valid;
  logic             out_free;
  logic             res_valid;
  hel_pkg::result_t res;
  hel_pkg::result_t out_data;

  // The result register takes a new result when it is empty or its current
  // transaction completes in this cycle.
  assign out_free = !out_valid || results.ready;

  hel_measure #(
    .SAMPLES_PER_MEASURE  (SAMPLES_PER_MEASURE),
    .CALIBRATION_MEASURES (CALIBRATION_MEASURES)
  ) u_measure (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_sum (start_sum),
    .band      (band),
    .out_free  (out_free),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register. It parts the two sides, so samples keep flowing while
  // a finished result waits to be taken, until a closing sample finds the unit busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  assign results.valid          = out_valid;
  assign results.lap_count      = out_data.lap_count;
  assign results.lap_event      = out_data.lap_event;
  assign results.baseline_level = out_data.baseline_level;
  assign results.measurement    = out_data.measurement;
  assign results.calibrated     = out_data.calibrated;

`ifndef SYNTHESIS
  // A group never enters the measurement unit while another is in flight.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("group handed over while measurement unit busy");

  // Laps are only counted after the baseline has been set.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.lap_event) |-> results.calibrated)
    else $error("lap counted before calibration");

  // A counted lap leaves a nonzero total.
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.lap_event) |-> (results.lap_count != '0))
    else $error("lap event with zero lap count");
`endif

endmodule
